// ===== rtl/core/pwsc_pkg.sv =====
// Package for the waypoint steering controller: word types, fixed-point
// constants, CORDIC angle table and small arithmetic helpers.
// No dependencies.
package pwsc_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int NSTEPS       = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int IW           = $clog2(NSTEPS);
  localparam int Q30_SH       = 30 - FRAC_BITS;
  localparam int PRE_SH       = 16;   // atan2 operand prescale (x65536)
  localparam int CW           = 54;   // CORDIC datapath width
  localparam int MW           = 34;   // multiplier operand width
  localparam int PW           = 2 * MW;
  localparam int AW           = 72;   // accumulator width

  // config register indexes
  localparam logic [3:0] REG_TARGET_X   = 4'd0;
  localparam logic [3:0] REG_TARGET_Y   = 4'd1;
  localparam logic [3:0] REG_LATERAL_KP = 4'd2;
  localparam logic [3:0] REG_LATERAL_KI = 4'd3;
  localparam logic [3:0] REG_LATERAL_KD = 4'd4;
  localparam logic [3:0] REG_HEADING_KP = 4'd5;
  localparam logic [3:0] REG_HEADING_KI = 4'd6;
  localparam logic [3:0] REG_HEADING_KD = 4'd7;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_t;

  typedef struct packed {
    logic signed [31:0] linear_cmd;
    logic signed [31:0] angular_cmd;
    logic               stopped;
  } out_t;

  typedef enum logic {
    CM_VEC = 1'b0,
    CM_ROT = 1'b1
  } cmode_e;

  typedef struct packed {
    logic   start;
    cmode_e mode;
  } cordic_req_t;

  function automatic logic signed [63:0] from_q30(input logic signed [63:0] v);
    return (v + (64'sd1 <<< (Q30_SH - 1))) >>> Q30_SH;
  endfunction

  localparam logic signed [31:0] PI_F      = 32'(from_q30(64'sd3373259426));
  localparam logic signed [31:0] HALF_PI_F = 32'(from_q30(64'sd1686629713));
  localparam logic signed [31:0] TWO_PI_F  = 32'(from_q30(64'sd6746518852));
  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(64'sd652032874);
  localparam logic signed [35:0] ONE_Q     = 36'sd1 <<< FRAC_BITS;
  localparam int DT_Q_I   = ((1 << FRAC_BITS) + 50) / 100;
  localparam int STOP_R_I = ((1 << FRAC_BITS) * 2 + 5) / 10;
  localparam logic signed [MW-1:0] DT_Q   = MW'(DT_Q_I);
  localparam logic signed [MW-1:0] DT_INV = MW'(100);
  localparam logic signed [MW-1:0] STOP_R = MW'(STOP_R_I);
  localparam logic signed [AW-1:0] STOP_R2 = AW'(STOP_R_I) * AW'(STOP_R_I);
  localparam logic signed [AW-1:0] S32_MAX = 72'sd2147483647;
  localparam logic signed [AW-1:0] S32_MIN = -72'sd2147483648;

  // arctan(2^-i) in Q.F
  function automatic logic signed [31:0] atan_f(input logic [4:0] idx);
    logic signed [63:0] v;
    unique case (idx)
      5'd0:    v = 64'sd843314857;
      5'd1:    v = 64'sd497837829;
      5'd2:    v = 64'sd263043837;
      5'd3:    v = 64'sd133525159;
      5'd4:    v = 64'sd67021687;
      5'd5:    v = 64'sd33543516;
      5'd6:    v = 64'sd16775851;
      5'd7:    v = 64'sd8388437;
      5'd8:    v = 64'sd4194283;
      5'd9:    v = 64'sd2097149;
      5'd10:   v = 64'sd1048576;
      5'd11:   v = 64'sd524288;
      5'd12:   v = 64'sd262144;
      5'd13:   v = 64'sd131072;
      5'd14:   v = 64'sd65536;
      5'd15:   v = 64'sd32768;
      5'd16:   v = 64'sd16384;
      5'd17:   v = 64'sd8192;
      5'd18:   v = 64'sd4096;
      5'd19:   v = 64'sd2048;
      5'd20:   v = 64'sd1024;
      5'd21:   v = 64'sd512;
      5'd22:   v = 64'sd256;
      5'd23:   v = 64'sd128;
      default: v = 64'sd0;
    endcase
    return 32'(from_q30(v));
  endfunction

  function automatic logic signed [33:0] wrap_pi(input logic signed [33:0] e);
    logic signed [33:0] pi34;
    logic signed [33:0] tp34;
    pi34 = 34'(PI_F);
    tp34 = 34'(TWO_PI_F);
    if (e < -pi34) begin
      return e + tp34;
    end else if (e > pi34) begin
      return e - tp34;
    end
    return e;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    if (v > S32_MAX) begin
      return 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // round half up and drop FRAC_BITS
  function automatic logic signed [AW-1:0] rnd_f(input logic signed [AW-1:0] v);
    return (v + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

endpackage

// ===== rtl/core/pwsc_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on pwsc_pkg.
module pwsc_mul (
  input  logic                           clk_i,
  input  logic signed [pwsc_pkg::MW-1:0] a_i,
  input  logic signed [pwsc_pkg::MW-1:0] b_i,
  output logic signed [pwsc_pkg::PW-1:0] p_o
);

  logic signed [pwsc_pkg::PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/pwsc_cordic.sv =====
// Iterative CORDIC: vectoring (atan2) and rotation (sin/cos), one
// micro-rotation per cycle. Depends on pwsc_pkg.
module pwsc_cordic (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pwsc_pkg::cordic_req_t       req_i,
  input  logic signed [33:0]          x_i,
  input  logic signed [33:0]          y_i,
  input  logic signed [31:0]          th_i,
  output logic                        done_o,
  output logic signed [31:0]          z_o,
  output logic signed [31:0]          sin_o,
  output logic signed [31:0]          cos_o
);

  localparam int CW = pwsc_pkg::CW;

  logic                      run_q, done_q, zero_q, neg_q;
  pwsc_pkg::cmode_e          mode_q;
  logic [pwsc_pkg::IW-1:0]   i_q;
  logic signed [CW-1:0]      x_q, y_q, x_n, y_n, dx, dy, xs, ys;
  logic signed [31:0]        z_q, z_n, ang, th_r;
  logic signed [CW-1:0]      c_r, s_r;
  logic                      dir, th_hi, th_lo;

  assign xs = {{(CW-34){x_i[33]}}, x_i} <<< pwsc_pkg::PRE_SH;
  assign ys = {{(CW-34){y_i[33]}}, y_i} <<< pwsc_pkg::PRE_SH;

  assign th_hi = th_i > pwsc_pkg::HALF_PI_F;
  assign th_lo = th_i < -pwsc_pkg::HALF_PI_F;
  always_comb begin
    th_r = th_i;
    if (th_hi) begin
      th_r = th_i - pwsc_pkg::PI_F;
    end else if (th_lo) begin
      th_r = th_i + pwsc_pkg::PI_F;
    end
  end

  // micro-rotation
  assign dx  = y_q >>> i_q;
  assign dy  = x_q >>> i_q;
  assign ang = pwsc_pkg::atan_f(5'(i_q));
  assign dir = (mode_q == pwsc_pkg::CM_VEC) ? y_q[CW-1] : ~z_q[31];

  always_comb begin
    if (dir) begin
      x_n = x_q - dx;
      y_n = y_q + dy;
      z_n = z_q - ang;
    end else begin
      x_n = x_q + dx;
      y_n = y_q - dy;
      z_n = z_q + ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      neg_q  <= 1'b0;
      mode_q <= pwsc_pkg::CM_VEC;
      i_q    <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      mode_q <= req_i.mode;
      i_q    <= '0;
      zero_q <= (req_i.mode == pwsc_pkg::CM_VEC) && (x_i == '0) && (y_i == '0);
      neg_q  <= (req_i.mode == pwsc_pkg::CM_ROT) && (th_hi || th_lo);
    end else if (run_q) begin
      if (i_q == pwsc_pkg::IW'(pwsc_pkg::NSTEPS - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        i_q <= i_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      if (req_i.mode == pwsc_pkg::CM_VEC) begin
        if (xs < 0) begin
          x_q <= -xs;
          y_q <= -ys;
          z_q <= (y_i >= 0) ? pwsc_pkg::PI_F : -pwsc_pkg::PI_F;
        end else begin
          x_q <= xs;
          y_q <= ys;
          z_q <= '0;
        end
      end else begin
        x_q <= pwsc_pkg::GAIN_Q30;
        y_q <= '0;
        z_q <= th_r;
      end
    end else if (run_q) begin
      x_q <= x_n;
      y_q <= y_n;
      z_q <= z_n;
    end
  end

  assign c_r = (x_q + (CW'(1) <<< (pwsc_pkg::Q30_SH - 1))) >>> pwsc_pkg::Q30_SH;
  assign s_r = (y_q + (CW'(1) <<< (pwsc_pkg::Q30_SH - 1))) >>> pwsc_pkg::Q30_SH;

  assign done_o = done_q;
  assign z_o    = zero_q ? 32'sd0 : z_q;
  assign cos_o  = neg_q ? -c_r[31:0] : c_r[31:0];
  assign sin_o  = neg_q ? -s_r[31:0] : s_r[31:0];

endmodule

// ===== rtl/core/pid_waypoint_steering_controller_top.sv =====
// Waypoint steering controller top: sequencer, config registers, PID state.
// Depends on pwsc_pkg, pwsc_mul and pwsc_cordic.
//
// One pose word in, one command word out. Each word takes three passes through
// the single iterative CORDIC (bearing to target, sin/cos of that bearing, yaw
// from the quaternion), multiply-accumulate work on the single 34x34
// multiplier (22 products) and a load of the output register. in_stall_o is
// high from accept until that load; the finished word sits in an output
// register, so a new pose is taken while it waits.
// Config writes are always accepted (cfg_ready_o tied high); change them
// only while the block is idle. Unknown register indexes are dropped.
module pid_waypoint_steering_controller_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pwsc_pkg::in_t      in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pwsc_pkg::out_t     out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int MW = pwsc_pkg::MW;
  localparam int AW = pwsc_pkg::AW;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_THETA  = 7'b0000010,
    S_SINCOS = 7'b0000100,
    S_MAC1   = 7'b0001000,
    S_YAW    = 7'b0010000,
    S_MAC2   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q;
  logic [3:0] step_q;

  // config
  logic signed [31:0] tx_q, ty_q, lkp_q, lki_q, lkd_q, hkp_q, hki_q, hkd_q;
  // controller state
  logic signed [31:0] li_q, hi_q, ll_q, lh_q;
  // datapath
  pwsc_pkg::in_t      in_q;
  logic signed [31:0] theta_q, sn_q, cs_q, el_q, et_q, del_q, det_q, w_q;
  logic signed [33:0] pq_q, qq_q, m20_q, yy_q;
  logic               stop_q;
  logic signed [AW-1:0] acc_q;
  pwsc_pkg::out_t     out_q;
  logic               out_valid_q;

  logic in_acc, out_acc, out_load;

  // shared units
  logic signed [MW-1:0] ma, mb;
  logic signed [pwsc_pkg::PW-1:0] prod;
  pwsc_pkg::cordic_req_t creq;
  logic signed [33:0] cx, cy;
  logic cdone;
  logic signed [31:0] cz, csin, ccos;

  pwsc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (ma),
    .b_i   (mb),
    .p_o   (prod)
  );

  pwsc_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .x_i    (cx),
    .y_i    (cy),
    .th_i   (cz),
    .done_o (cdone),
    .z_o    (cz),
    .sin_o  (csin),
    .cos_o  (ccos)
  );

  assign in_acc      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

  // position error, exact
  logic signed [32:0] ex, ey;
  logic signed [33:0] ex_abs, ey_abs;
  logic               near;
  assign ex     = {in_q.pos_x[31], in_q.pos_x} - {tx_q[31], tx_q};
  assign ey     = {in_q.pos_y[31], in_q.pos_y} - {ty_q[31], ty_q};
  assign ex_abs = ex[32] ? -{ex[32], ex} : {ex[32], ex};
  assign ey_abs = ey[32] ? -{ey[32], ey} : {ey[32], ey};
  assign near   = (ex_abs <= pwsc_pkg::STOP_R) && (ey_abs <= pwsc_pkg::STOP_R);

  // quaternion terms
  logic signed [33:0] nrm, xx, m20_abs;
  assign nrm     = pq_q + qq_q;
  assign xx      = pq_q - qq_q;
  assign m20_abs = m20_q[33] ? -m20_q : m20_q;

  // differences for derivative terms
  logic signed [33:0] dl, dh;
  assign dl = 34'(el_q) - 34'(ll_q);
  assign dh = pwsc_pkg::wrap_pi(34'(et_q) - 34'(lh_q));

  // product, plain and rounded
  logic signed [AW-1:0] pext, prnd;
  assign pext = {{(AW - pwsc_pkg::PW){prod[pwsc_pkg::PW-1]}}, prod};
  assign prnd = pwsc_pkg::rnd_f(pext);

  // cordic requests: target bearing, its sin/cos, then yaw
  always_comb begin
    creq.start = (in_acc)
              || (state_q == S_THETA && cdone)
              || (state_q == S_MAC1 && step_q == 4'd12);
    creq.mode  = (state_q == S_THETA) ? pwsc_pkg::CM_ROT : pwsc_pkg::CM_VEC;
    if (state_q == S_IDLE) begin
      cx = 34'(tx_q);
      cy = 34'(ty_q);
    end else begin
      cx = xx;
      cy = yy_q;
    end
  end

  // multiplier issue schedule
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == S_MAC1) begin
      case (step_q)
        4'd0:    begin ma = MW'(ex);          mb = MW'(sn_q);        end
        4'd1:    begin ma = MW'(ey);          mb = MW'(cs_q);        end
        4'd2:    begin ma = MW'(in_q.quat_w); mb = MW'(in_q.quat_w); end
        4'd3:    begin ma = MW'(in_q.quat_x); mb = MW'(in_q.quat_x); end
        4'd4:    begin ma = MW'(in_q.quat_y); mb = MW'(in_q.quat_y); end
        4'd5:    begin ma = MW'(in_q.quat_z); mb = MW'(in_q.quat_z); end
        4'd6:    begin ma = MW'(in_q.quat_x); mb = MW'(in_q.quat_z); end
        4'd7:    begin ma = MW'(in_q.quat_w); mb = MW'(in_q.quat_y); end
        4'd8:    begin ma = MW'(in_q.quat_x); mb = MW'(in_q.quat_y); end
        4'd9:    begin ma = MW'(in_q.quat_w); mb = MW'(in_q.quat_z); end
        4'd10:   begin ma = MW'(ex);          mb = MW'(ex);          end
        4'd11:   begin ma = MW'(ey);          mb = MW'(ey);          end
        default: begin ma = '0;               mb = '0;               end
      endcase
    end else if (state_q == S_MAC2) begin
      case (step_q)
        4'd0:    begin ma = MW'(el_q);  mb = pwsc_pkg::DT_Q;   end
        4'd1:    begin ma = MW'(et_q);  mb = pwsc_pkg::DT_Q;   end
        4'd2:    begin ma = dl;         mb = pwsc_pkg::DT_INV; end
        4'd3:    begin ma = dh;         mb = pwsc_pkg::DT_INV; end
        4'd4:    begin ma = MW'(hkp_q); mb = MW'(et_q);        end
        4'd5:    begin ma = MW'(hkd_q); mb = MW'(det_q);       end
        4'd6:    begin ma = MW'(hki_q); mb = MW'(hi_q);        end
        4'd7:    begin ma = MW'(lkp_q); mb = MW'(el_q);        end
        4'd8:    begin ma = MW'(lkd_q); mb = MW'(del_q);       end
        4'd9:    begin ma = MW'(lki_q); mb = MW'(li_q);        end
        default: begin ma = '0;         mb = '0;               end
      endcase
    end
  end

  // linear speed before the stop override
  logic signed [35:0] el_abs, et_abs, vlin;
  logic signed [31:0] v_sat;
  assign el_abs = el_q[31] ? -36'(el_q) : 36'(el_q);
  assign et_abs = et_q[31] ? -36'(et_q) : 36'(et_q);
  assign vlin   = pwsc_pkg::ONE_Q - el_abs - et_abs;
  assign v_sat  = pwsc_pkg::sat32(AW'(vlin));

  // sequencer, config and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      tx_q        <= 32'sd153354;
      ty_q        <= 32'sd229376;
      lkp_q       <= 32'sd65536;
      lki_q       <= 32'sd655;
      lkd_q       <= 32'sd655;
      hkp_q       <= 32'sd32768;
      hki_q       <= 32'sd655;
      hkd_q       <= 32'sd655;
      li_q        <= '0;
      hi_q        <= '0;
      ll_q        <= '0;
      lh_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pwsc_pkg::REG_TARGET_X:   tx_q  <= cfg_data_i;
          pwsc_pkg::REG_TARGET_Y:   ty_q  <= cfg_data_i;
          pwsc_pkg::REG_LATERAL_KP: lkp_q <= cfg_data_i;
          pwsc_pkg::REG_LATERAL_KI: lki_q <= cfg_data_i;
          pwsc_pkg::REG_LATERAL_KD: lkd_q <= cfg_data_i;
          pwsc_pkg::REG_HEADING_KP: hkp_q <= cfg_data_i;
          pwsc_pkg::REG_HEADING_KI: hki_q <= cfg_data_i;
          pwsc_pkg::REG_HEADING_KD: hkd_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_THETA;
          end
        end
        S_THETA: begin
          if (cdone) begin
            state_q <= S_SINCOS;
          end
        end
        S_SINCOS: begin
          if (cdone) begin
            state_q <= S_MAC1;
            step_q  <= '0;
          end
        end
        S_MAC1: begin
          if (step_q == 4'd12) begin
            state_q <= S_YAW;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        S_YAW: begin
          if (cdone) begin
            state_q <= S_MAC2;
            step_q  <= '0;
          end
        end
        S_MAC2: begin
          if (step_q == 4'd1) begin
            li_q <= pwsc_pkg::sat32(AW'(li_q) + prnd);
          end
          if (step_q == 4'd2) begin
            hi_q <= pwsc_pkg::sat32(AW'(hi_q) + prnd);
          end
          if (step_q == 4'd10) begin
            ll_q    <= el_q;
            lh_q    <= et_q;
            state_q <= S_DONE;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_i;
    end
    if (state_q == S_THETA && cdone) begin
      theta_q <= cz;
    end
    if (state_q == S_SINCOS && cdone) begin
      sn_q <= csin;
      cs_q <= ccos;
    end
    if (state_q == S_MAC1) begin
      case (step_q)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11: acc_q <= pext;
        4'd2:  el_q   <= pwsc_pkg::sat32(pwsc_pkg::rnd_f(acc_q - pext));
        4'd4:  pq_q   <= 34'(acc_q + pext);
        4'd6:  qq_q   <= 34'(acc_q + pext);
        4'd8:  m20_q  <= 34'((acc_q - pext) <<< 1);
        4'd10: yy_q   <= 34'((acc_q + pext) <<< 1);
        4'd12: stop_q <= near && ((acc_q + pext) <= pwsc_pkg::STOP_R2);
        default: ;
      endcase
    end
    if (state_q == S_YAW && cdone) begin
      // gimbal lock or a null quaternion gives zero yaw
      et_q <= 32'(pwsc_pkg::wrap_pi(34'(theta_q)
                  - ((m20_abs >= nrm) ? 34'sd0 : 34'(cz))));
    end
    if (state_q == S_MAC2) begin
      case (step_q)
        4'd3:  del_q <= pwsc_pkg::sat32(pext);
        4'd4:  det_q <= pwsc_pkg::sat32(pext);
        4'd5:  acc_q <= prnd;
        4'd6, 4'd7, 4'd8, 4'd9: acc_q <= acc_q + prnd;
        4'd10: w_q   <= pwsc_pkg::sat32(acc_q + prnd);
        default: ;
      endcase
    end
    if (out_load) begin
      out_q.linear_cmd  <= stop_q ? 32'sd0 : v_sat;
      out_q.angular_cmd <= stop_q ? 32'sd0 : w_q;
      out_q.stopped     <= stop_q;
    end
  end

`ifndef SYNTHESIS
  a_cdone_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdone |-> (state_q == S_THETA || state_q == S_SINCOS || state_q == S_YAW))
    else $error("cordic finished outside a cordic phase");

  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.stopped |-> out_o.linear_cmd == 32'sd0
                                   && out_o.angular_cmd == 32'sd0)
    else $error("stopped word carries nonzero commands");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_THETA)
    else $error("accepted pose did not start the bearing pass");

  a_done_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == S_IDLE)
    else $error("finished word not presented");
`endif

endmodule

// ===== tb/pid_waypoint_steering_controller_top_tb.sv =====
// Self-checking testbench for the waypoint steering controller top level.
// Needs pwsc_pkg and the controller RTL. A behavioral predictor built on
// fixed-point integer math computes each expected command word.
`timescale 1ns / 100ps

module pid_waypoint_steering_controller_top_tb;

  localparam int WATCHDOG_CYCLES = 20000;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  pwsc_pkg::in_t   in_i;
  logic            out_valid_o;
  logic            out_stall_i;
  pwsc_pkg::out_t  out_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [3:0]      cfg_index_i;
  logic [31:0]     cfg_data_i;

  pid_waypoint_steering_controller_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .out_valid_o, .out_stall_i, .out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // predictor copy of the registers and the PID state
  longint goal_x, goal_y, lat_kp, lat_ki, lat_kd, hdg_kp, hdg_ki, hdg_kd;
  longint lat_integ, hdg_integ, lat_prev, hdg_prev;

  pwsc_pkg::in_t  pose_q[$];      // poses waiting for the driver
  pwsc_pkg::out_t command_q[$];   // expected command words, oldest first
  int     mismatches;
  int     idle_pct;       // chance of a gap/stall, in percent
  bit     hold_sender;    // sender held off until all commands drain
  int     quiet_cycles;
  bit     timed_out;

  // arithmetic shift right that floors, like the RTL
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint q30_to_f(longint v);
    return round_shr(v, 30 - pwsc_pkg::FRAC_BITS);
  endfunction

  function automatic longint atan_entry(int i);
    longint tab [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return q30_to_f(tab[i]);
  endfunction

  function automatic longint wrap_angle(longint e);
    longint pi_f;
    pi_f = q30_to_f(64'sd3373259426);
    if (e < -pi_f) return e + q30_to_f(64'sd6746518852);
    if (e > pi_f) return e - q30_to_f(64'sd6746518852);
    return e;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 65536;
    y = y * 65536;
    if (x < 0) begin
      z = (y >= 0) ? q30_to_f(64'sd3373259426) : -q30_to_f(64'sd3373259426);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < pwsc_pkg::CORDIC_STEPS && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (y < 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    return z;
  endfunction

  function automatic void rotate_angle(input longint th, output longint sn,
                                       output longint cs);
    bit     flip;
    longint x, y, dx, dy;
    flip = 0;
    x = 652032874;
    y = 0;
    if (th > q30_to_f(64'sd1686629713)) begin
      th -= q30_to_f(64'sd3373259426); flip = 1;
    end else if (th < -q30_to_f(64'sd1686629713)) begin
      th += q30_to_f(64'sd3373259426); flip = 1;
    end
    for (int i = 0; i < pwsc_pkg::CORDIC_STEPS && i < 24; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (th >= 0) begin
        x -= dx; y += dy; th -= atan_entry(i);
      end else begin
        x += dx; y -= dy; th += atan_entry(i);
      end
    end
    cs = q30_to_f(x);
    sn = q30_to_f(y);
    if (flip) begin
      cs = -cs; sn = -sn;
    end
  endfunction

  function automatic void reset_model();
    goal_x = 153354; goal_y = 229376;
    lat_kp = 65536; lat_ki = 655; lat_kd = 655;
    hdg_kp = 32768; hdg_ki = 655; hdg_kd = 655;
    lat_integ = 0; hdg_integ = 0; lat_prev = 0; hdg_prev = 0;
  endfunction

  function automatic void apply_register(logic [3:0] idx, logic [31:0] data);
    longint v;
    v = longint'(signed'(data));
    case (idx)
      pwsc_pkg::REG_TARGET_X:   goal_x = v;
      pwsc_pkg::REG_TARGET_Y:   goal_y = v;
      pwsc_pkg::REG_LATERAL_KP: lat_kp = v;
      pwsc_pkg::REG_LATERAL_KI: lat_ki = v;
      pwsc_pkg::REG_LATERAL_KD: lat_kd = v;
      pwsc_pkg::REG_HEADING_KP: hdg_kp = v;
      pwsc_pkg::REG_HEADING_KI: hdg_ki = v;
      pwsc_pkg::REG_HEADING_KD: hdg_kd = v;
      default: ;
    endcase
  endfunction

  // steering law for one pose; updates integrals and previous errors
  function automatic pwsc_pkg::out_t steer(pwsc_pkg::in_t p);
    longint qx, qy, qz, qw, bearing, ex, ey, sn, cs, lat_e, hdg_e, yaw;
    longint d_lat, d_hdg, turn, speed, nrm, m20, dt_q, stop_r;
    bit     halt;
    pwsc_pkg::out_t r;
    qx = p.quat_x; qy = p.quat_y; qz = p.quat_z; qw = p.quat_w;
    dt_q = ((longint'(1) << pwsc_pkg::FRAC_BITS) + 50) / 100;
    stop_r = ((longint'(1) << pwsc_pkg::FRAC_BITS) * 2 + 5) / 10;
    bearing = vector_angle(goal_y, goal_x);
    ex = longint'(p.pos_x) - goal_x;
    ey = longint'(p.pos_y) - goal_y;
    rotate_angle(bearing, sn, cs);
    lat_e = clamp32(round_shr(ex * sn - ey * cs, pwsc_pkg::FRAC_BITS));
    nrm = qx * qx + qy * qy + qz * qz + qw * qw;
    m20 = 2 * (qx * qz - qw * qy);
    if ((m20 < 0 ? -m20 : m20) >= nrm) yaw = 0;
    else yaw = vector_angle(2 * (qx * qy + qw * qz),
                            qw * qw + qx * qx - qy * qy - qz * qz);
    hdg_e = wrap_angle(bearing - yaw);
    lat_integ = clamp32(lat_integ + round_shr(lat_e * dt_q, pwsc_pkg::FRAC_BITS));
    hdg_integ = clamp32(hdg_integ + round_shr(hdg_e * dt_q, pwsc_pkg::FRAC_BITS));
    d_lat = clamp32((lat_e - lat_prev) * 100);
    d_hdg = clamp32(wrap_angle(hdg_e - hdg_prev) * 100);
    turn = round_shr(hdg_kp * hdg_e, pwsc_pkg::FRAC_BITS)
         + round_shr(hdg_kd * d_hdg, pwsc_pkg::FRAC_BITS)
         + round_shr(hdg_ki * hdg_integ, pwsc_pkg::FRAC_BITS)
         + round_shr(lat_kp * lat_e, pwsc_pkg::FRAC_BITS)
         + round_shr(lat_kd * d_lat, pwsc_pkg::FRAC_BITS)
         + round_shr(lat_ki * lat_integ, pwsc_pkg::FRAC_BITS);
    turn = clamp32(turn);
    speed = clamp32((longint'(1) << pwsc_pkg::FRAC_BITS) - (lat_e < 0 ? -lat_e : lat_e)
                    - (hdg_e < 0 ? -hdg_e : hdg_e));
    if ((ex < 0 ? -ex : ex) > stop_r || (ey < 0 ? -ey : ey) > stop_r) halt = 0;
    else halt = (ex * ex + ey * ey) <= stop_r * stop_r;
    if (halt) begin
      speed = 0; turn = 0;
    end
    lat_prev = lat_e;
    hdg_prev = hdg_e;
    r.linear_cmd = speed[31:0];
    r.angular_cmd = turn[31:0];
    r.stopped = halt;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // pose driver: valid held steady while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) command_q.push_back(steer(in_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pose_q.size() != 0 && !hold_sender && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_i <= pose_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // command monitor with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (command_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected command word %p", out_o);
        end else begin
          pwsc_pkg::out_t want;
          want = command_q.pop_front();
          if (want !== out_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("command mismatch: expected %p, got %p", want, out_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG_CYCLES && !timed_out) begin
      timed_out = 1;
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] rand_quat_part();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_pos(longint center);
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom);
      3, 4: return 32'(center + $signed($urandom_range(26000)) - 13000);
      default: return 32'(center + $signed($urandom_range(800000)) - 400000);
    endcase
  endfunction

  function automatic pwsc_pkg::in_t random_pose();
    pwsc_pkg::in_t p;
    p.pos_x = rand_pos(goal_x);
    p.pos_y = rand_pos(goal_y);
    p.quat_x = rand_quat_part();
    p.quat_y = rand_quat_part();
    p.quat_z = rand_quat_part();
    p.quat_w = rand_quat_part();
    if ($urandom_range(3) == 0) begin
      // planar heading: yaw only
      p.quat_x = 0; p.quat_y = 0;
    end
    return p;
  endfunction

  function automatic pwsc_pkg::in_t make_pose(longint x, longint y, logic [15:0] qx,
                                              logic [15:0] qy, logic [15:0] qz,
                                              logic [15:0] qw);
    pwsc_pkg::in_t p;
    p.pos_x = 32'(x); p.pos_y = 32'(y);
    p.quat_x = qx; p.quat_y = qy; p.quat_z = qz; p.quat_w = qw;
    return p;
  endfunction

  task automatic wait_drained();
    while (pose_q.size() != 0 || in_valid_i || command_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_register(logic [3:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_register(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_setting(longint tx, longint ty, longint lp, longint li, longint ld,
                               longint hp, longint hi, longint hd);
    write_register(pwsc_pkg::REG_TARGET_X, 32'(tx));
    write_register(pwsc_pkg::REG_TARGET_Y, 32'(ty));
    write_register(pwsc_pkg::REG_LATERAL_KP, 32'(lp));
    write_register(pwsc_pkg::REG_LATERAL_KI, 32'(li));
    write_register(pwsc_pkg::REG_LATERAL_KD, 32'(ld));
    write_register(pwsc_pkg::REG_HEADING_KP, 32'(hp));
    write_register(pwsc_pkg::REG_HEADING_KI, 32'(hi));
    write_register(pwsc_pkg::REG_HEADING_KD, 32'(hd));
  endtask

  // gap rate changes once the driver has used up the poses queued so far
  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 3 || n == count / 2) begin
        while (pose_q.size() != 0) @(posedge clk_i);
        idle_pct = (n == count / 3) ? 0 : 27;   // stretch with no gaps
      end
      pose_q.push_back(random_pose());
    end
    wait_drained();
  endtask

  initial begin
    mismatches = 0;
    timed_out = 0;
    idle_pct = 27;
    hold_sender = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    reset_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: stop radius, quaternion corners, field extremes
    pose_q.push_back(make_pose(goal_x, goal_y, 0, 0, 0, 0));
    pose_q.push_back(make_pose(goal_x + 13107, goal_y, 0, 0, 0, 16'h7fff));
    pose_q.push_back(make_pose(goal_x + 13108, goal_y, 0, 0, 16'h7fff, 0));
    pose_q.push_back(make_pose(goal_x + 9000, goal_y - 9000, 0, 0, 16'h8000, 16'h8000));
    pose_q.push_back(make_pose(0, 0, 16'h5a82, 0, 0, 16'h5a82));
    pose_q.push_back(make_pose(0, 0, 0, 16'h5a82, 0, 16'h5a82));
    pose_q.push_back(make_pose(0, 0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    pose_q.push_back(make_pose(0, 0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    pose_q.push_back(make_pose(-64'sd2147483648, -64'sd2147483648, 0, 0, 16'h7fff, 16'h8000));
    pose_q.push_back(make_pose(64'sd2147483647, 64'sd2147483647, 0, 0, 16'h8000, 16'h7fff));
    pose_q.push_back(make_pose(64'sd2147483647, -64'sd2147483648, 0, 0, 16'h4000, 16'h0));
    pose_q.push_back(make_pose(-64'sd2147483648, 64'sd2147483647, 0, 0, 16'hc000, 16'h1));
    wait_drained();

    // target at origin, extreme gains
    write_setting(0, 0, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
                  -64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
    pose_q.push_back(make_pose(0, 0, 0, 0, 0, 0));
    pose_q.push_back(make_pose(64'sd2147483647, 5, 0, 0, 16'h7fff, 16'h0));
    pose_q.push_back(make_pose(-64'sd2147483648, -5, 0, 0, 16'h8000, 16'h1));
    pose_q.push_back(make_pose(1000, -1000, 0, 0, 16'h3000, 16'h7000));
    wait_drained();
    // unknown register index must be ignored
    write_register(4'd8, 32'hdead_beef);
    write_register(4'd15, 32'h1234_5678);
    run_random(250);

    // sender holds off mid-stream until every command is back
    for (int n = 0; n < 20; n++) pose_q.push_back(random_pose());
    repeat (300) @(posedge clk_i);
    hold_sender = 1;
    while (in_valid_i || command_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    hold_sender = 0;
    wait_drained();

    write_setting(153354, 229376, 65536, 655, 655, 32768, 655, 655);
    run_random(450);

    write_setting(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 0, 0,
                  64'sd2147483647, 0, 0);
    run_random(150);

    write_setting(-200000, -5, 200000, 3000, 500, 100000, 2000, 800);
    run_random(300);

    write_setting(64'sd2147483647, -64'sd2147483648, 0, -64'sd2147483648,
                  64'sd2147483647, 0, 64'sd2147483647, -64'sd2147483648);
    run_random(150);

    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && command_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
